// ===== design/hrf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and character tables for the HTTP request framer.
// No dependencies; imported by hrf_line_scan and http_request_framer.
package hrf_pkg;

  localparam int LEN_W          = 24;
  localparam int COUNT_BITS_DEF = 24;
  localparam int CFG_IDX_W      = 1;

  localparam logic [LEN_W-1:0] BODY_LIMIT_RST  = 24'd1048576;
  localparam logic [LEN_W-1:0] REQUEST_CAP_RST = 24'd1056768;
  localparam logic [LEN_W-1:0] LEN_MAX         = 24'hFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_CAP = 1'b1;

  localparam int VER_PREFIX_LEN = 7;
  localparam int NAME_LEN       = 14;

  // Bit positions in line_flags.
  localparam int LF_TOKEN = 0;
  localparam int LF_COLON = 0;
  localparam int LF_MISM  = 1;
  localparam int LF_NEG   = 2;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;

  typedef enum logic [1:0] {
    KIND_BODY     = 2'd0,
    KIND_HDR_DONE = 2'd1,
    KIND_REJECT   = 2'd2,
    KIND_CLOSED   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_MALFORMED = 2'd0,
    ERR_VERSION   = 2'd1,
    ERR_CAP       = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    VS_NONE   = 2'd0,
    VS_PREFIX = 2'd1,
    VS_HTTP10 = 2'd2,
    VS_HTTP11 = 2'd3
  } ver_state_t;

  typedef enum logic [1:0] {
    VAL_SKIP   = 2'd0,
    VAL_SIGN   = 2'd1,
    VAL_DIGITS = 2'd2,
    VAL_STOP   = 2'd3
  } val_state_t;

  typedef enum logic [3:0] {
    PH_LINE = 4'b0001,
    PH_HEAD = 4'b0010,
    PH_BODY = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]       token_index;
    logic [3:0]       ver_pos;
    ver_state_t       ver_state;
    logic [3:0]       name_pos;
    logic [2:0]       line_flags;
    val_state_t       value_state;
    logic [LEN_W-1:0] length_accum;
    logic             length_found;
  } scan_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       closed;
  } in_item_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       body_byte;
    logic             body_last;
    logic [LEN_W-1:0] content_length;
    logic             version_minor;
    err_t             error_code;
  } out_item_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // "HTTP/1." one character at a time.
  function automatic logic [7:0] ver_lit(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'h48;
      3'd1:    c = 8'h54;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h50;
      3'd4:    c = 8'h2F;
      3'd5:    c = 8'h31;
      3'd6:    c = 8'h2E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "content-length" one character at a time.
  function automatic logic [7:0] name_lit(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/http_request_framer.sv =====
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Payload
// in        | input     | in_valid / in_stall   | in_data  (data_byte, closed)
// out       | output    | out_valid / out_stall | out_data (kind .. error_code)
// cfg       | input     | cfg_we               | cfg_index, cfg_data
//
// One byte is taken per clock while in_stall is low; each transaction gives at
// most one result, held in the output register from the cycle after. The limit
// is the single byte scan that updates the header state. in_stall rises only
// while a result waits in the output register and out_stall is high. rst_n is
// synchronous and clears the parse state and reloads the register defaults.
//
// Top level of the HTTP request framer. Depends on hrf_pkg and hrf_line_scan.
module http_request_framer #(
  parameter int COUNT_BITS = hrf_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  hrf_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output hrf_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [hrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrf_pkg::LEN_W-1:0]      cfg_data
);
  import hrf_pkg::*;

  localparam int CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [LEN_W-1:0]      body_limit_r, request_cap_r;
  phase_t                phase_r, phase_nxt;
  scan_t                 scan_r, scan_nxt, scan_upd;
  logic [1:0]            crlf_r, crlf_nxt;
  logic [COUNT_BITS-1:0] byte_total_r, byte_total_nxt, total_inc;
  logic [LEN_W-1:0]      body_rem_r, body_rem_nxt, rem_dec, hdr_len;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, res;
  logic                  produce, accept;
  logic                  line_end, hdr_end, cap_before, cap_after, hdr_last;
  logic [7:0]            c;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign c         = in_data.data_byte;

  assign line_end  = (c == CH_LF) && crlf_r[0];
  assign hdr_end   = line_end && (crlf_r == 2'd3);
  assign total_inc = (byte_total_r == CNT_MAX) ? byte_total_r
                                               : byte_total_r + COUNT_BITS'(1);
  assign rem_dec   = (body_rem_r != '0) ? body_rem_r - LEN_W'(1) : body_rem_r;
  assign cap_before = CMP_W'(byte_total_r) >= CMP_W'(request_cap_r);
  assign cap_after  = CMP_W'(total_inc) >= CMP_W'(request_cap_r);
  assign hdr_len   = !scan_r.length_found ? '0 :
                     (scan_r.length_accum < body_limit_r) ? scan_r.length_accum : body_limit_r;
  assign hdr_last  = (hdr_len == '0) || cap_after;

  hrf_line_scan u_scan (
    .scan_i     (scan_r),
    .byte_i     (c),
    .line_end_i (line_end),
    .req_line_i (phase_r == PH_LINE),
    .scan_o     (scan_upd)
  );

  always_comb begin
    phase_nxt      = phase_r;
    scan_nxt       = scan_r;
    crlf_nxt       = crlf_r;
    byte_total_nxt = byte_total_r;
    body_rem_nxt   = body_rem_r;
    produce        = 1'b0;
    res            = '0;
    if (accept) begin
      if (in_data.closed) begin
        if (phase_r != PH_DONE) begin
          produce  = 1'b1;
          res.kind = KIND_CLOSED;
        end
        phase_nxt      = PH_LINE;
        scan_nxt       = '0;
        crlf_nxt       = '0;
        byte_total_nxt = '0;
        body_rem_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_BODY: begin
            byte_total_nxt = total_inc;
            body_rem_nxt   = rem_dec;
            produce        = 1'b1;
            res.kind       = KIND_BODY;
            res.body_byte  = c;
            res.body_last  = (rem_dec == '0) || cap_after;
            if (res.body_last) begin
              phase_nxt = PH_DONE;
            end
          end
          PH_LINE, PH_HEAD: begin
            if (cap_before) begin
              produce        = 1'b1;
              res.kind       = KIND_REJECT;
              res.error_code = ERR_CAP;
              phase_nxt      = PH_DONE;
            end else begin
              byte_total_nxt = total_inc;
              if (c == CH_CR) begin
                crlf_nxt = (crlf_r == 2'd2) ? 2'd3 : 2'd1;
              end else if (line_end) begin
                crlf_nxt = (crlf_r == 2'd1) ? 2'd2 : 2'd0;
              end else begin
                crlf_nxt = 2'd0;
              end
              if (phase_r == PH_HEAD && hdr_end) begin
                // Header complete: the verdict stands even on the byte at the cap.
                produce = 1'b1;
                if (scan_r.token_index != 2'd3) begin
                  res.kind       = KIND_REJECT;
                  res.error_code = ERR_MALFORMED;
                  phase_nxt      = PH_DONE;
                end else if (scan_r.ver_state == VS_NONE || scan_r.ver_state == VS_PREFIX) begin
                  res.kind       = KIND_REJECT;
                  res.error_code = ERR_VERSION;
                  phase_nxt      = PH_DONE;
                end else begin
                  res.kind           = KIND_HDR_DONE;
                  res.body_last      = hdr_last;
                  res.content_length = hdr_len;
                  res.version_minor  = (scan_r.ver_state == VS_HTTP11);
                  body_rem_nxt       = hdr_len;
                  phase_nxt          = hdr_last ? PH_DONE : PH_BODY;
                end
              end else begin
                scan_nxt = scan_upd;
                if (phase_r == PH_LINE && line_end) begin
                  phase_nxt = PH_HEAD;
                end
                if (cap_after) begin
                  produce        = 1'b1;
                  res.kind       = KIND_REJECT;
                  res.error_code = ERR_CAP;
                  phase_nxt      = PH_DONE;
                end
              end
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_comb begin
    if (accept && produce) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      body_limit_r  <= BODY_LIMIT_RST;
      request_cap_r <= REQUEST_CAP_RST;
      phase_r       <= PH_LINE;
      scan_r        <= '0;
      crlf_r        <= '0;
      byte_total_r  <= '0;
      body_rem_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BODY_LIMIT:  body_limit_r  <= cfg_data;
          CFG_REQUEST_CAP: request_cap_r <= cfg_data;
          default:         body_limit_r  <= body_limit_r;
        endcase
      end
      phase_r      <= phase_nxt;
      scan_r       <= scan_nxt;
      crlf_r       <= crlf_nxt;
      byte_total_r <= byte_total_nxt;
      body_rem_r   <= body_rem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && produce) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  // In the body phase there is always at least one byte still owed.
  a_body_owed: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> body_rem_r != '0)
    else $error("body phase entered with nothing left to forward");

  // A finished request produces nothing until the connection closes.
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_data.closed && phase_r == PH_DONE) |-> !produce)
    else $error("result produced after completion");

  // Body bytes come only from the body phase.
  a_body_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && res.kind == KIND_BODY) |-> phase_r == PH_BODY)
    else $error("body byte outside the body phase");

  // Headers done without a last mark must open the body phase.
  a_hdr_to_body: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && res.kind == KIND_HDR_DONE && !res.body_last) |=> phase_r == PH_BODY)
    else $error("headers done did not start the body");

  // A close clears the connection state.
  a_close_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.closed) |=> (phase_r == PH_LINE && byte_total_r == '0))
    else $error("close did not reset the connection state");
`endif

endmodule

// ===== design/hrf_line_scan.sv =====
`timescale 1ns / 1ps
// Per-byte scanner for the request line and header lines: token count, version
// match, content-length name match and value parsing. Depends on hrf_pkg.
module hrf_line_scan (
  input  hrf_pkg::scan_t scan_i,
  input  logic [7:0]     byte_i,
  input  logic           line_end_i,
  input  logic           req_line_i,
  output hrf_pkg::scan_t scan_o
);
  import hrf_pkg::*;

  logic [7:0]       lc;
  logic [3:0]       digit;
  logic [LEN_W+3:0] accum_x10;

  always_comb begin
    lc = (byte_i >= CH_UC_A && byte_i <= CH_UC_Z) ? byte_i + 8'd32 : byte_i;
    digit = 4'(byte_i - CH_0);
    accum_x10 = {scan_i.length_accum, 3'b000} + {3'b000, scan_i.length_accum, 1'b0}
                + {{(LEN_W){1'b0}}, digit};
  end

  always_comb begin
    scan_o = scan_i;
    if (req_line_i) begin
      if (line_end_i) begin
        scan_o.line_flags  = '0;
        scan_o.name_pos    = '0;
        scan_o.value_state = VAL_SKIP;
      end else if (is_ws(byte_i)) begin
        if (scan_i.line_flags[LF_TOKEN]) begin
          scan_o.line_flags = '0;
          if (scan_i.token_index != 2'd3) begin
            scan_o.token_index = scan_i.token_index + 2'd1;
          end
        end
      end else begin
        if (!scan_i.line_flags[LF_TOKEN]) begin
          scan_o.line_flags = 3'b001;
          if (scan_i.token_index == 2'd2) begin
            scan_o.ver_state = VS_PREFIX;
            scan_o.ver_pos   = '0;
          end
        end
        // The third token is checked against the version strings as it arrives.
        if (scan_i.token_index == 2'd2) begin
          if (scan_o.ver_state == VS_PREFIX) begin
            if (scan_o.ver_pos < 4'(VER_PREFIX_LEN)) begin
              if (byte_i == ver_lit(scan_o.ver_pos[2:0])) begin
                scan_o.ver_pos = scan_o.ver_pos + 4'd1;
              end else begin
                scan_o.ver_state = VS_NONE;
              end
            end else begin
              scan_o.ver_state = (byte_i == CH_1) ? VS_HTTP11 :
                                 (byte_i == CH_0) ? VS_HTTP10 : VS_NONE;
              scan_o.ver_pos   = 4'(VER_PREFIX_LEN + 1);
            end
          end else if (scan_o.ver_state == VS_HTTP10 || scan_o.ver_state == VS_HTTP11) begin
            scan_o.ver_state = VS_NONE;
          end
        end
      end
    end else begin
      if (line_end_i) begin
        scan_o.line_flags  = '0;
        scan_o.name_pos    = '0;
        scan_o.value_state = VAL_SKIP;
      end else if (!scan_i.line_flags[LF_COLON]) begin
        if (byte_i == CH_COLON) begin
          scan_o.line_flags[LF_COLON] = 1'b1;
          if (!scan_i.line_flags[LF_MISM] && scan_i.name_pos == 4'(NAME_LEN)
              && !scan_i.length_found) begin
            scan_o.length_found = 1'b1;
            scan_o.length_accum = '0;
            scan_o.value_state  = VAL_SKIP;
          end else begin
            scan_o.value_state = VAL_STOP;
          end
        end else if (scan_i.name_pos < 4'(NAME_LEN) && lc == name_lit(scan_i.name_pos)) begin
          scan_o.name_pos = scan_i.name_pos + 4'd1;
        end else begin
          scan_o.line_flags[LF_MISM] = 1'b1;
        end
      end else if (scan_i.value_state != VAL_STOP) begin
        if (byte_i >= CH_0 && byte_i <= CH_9) begin
          scan_o.value_state = VAL_DIGITS;
          // A negative value ends as zero, so its digits are not accumulated.
          if (!scan_i.line_flags[LF_NEG]) begin
            scan_o.length_accum = (accum_x10 > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX
                                                                    : accum_x10[LEN_W-1:0];
          end
        end else if (scan_i.value_state == VAL_SKIP && is_ws(byte_i)) begin
          scan_o.value_state = VAL_SKIP;
        end else if (scan_i.value_state == VAL_SKIP && byte_i == CH_PLUS) begin
          scan_o.value_state = VAL_SIGN;
        end else if (scan_i.value_state == VAL_SKIP && byte_i == CH_MINUS) begin
          scan_o.value_state = VAL_SIGN;
          scan_o.line_flags[LF_NEG] = 1'b1;
        end else begin
          scan_o.value_state = VAL_STOP;
        end
      end
    end
  end

endmodule
